// ===== hw/rtl/scanned_encoder_bank_decoder_top_defines.svh =====
// Assertion macros for the scanned encoder bank decoder.
`ifndef SCANNED_ENCODER_BANK_DECODER_TOP_DEFINES_SVH
`define SCANNED_ENCODER_BANK_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that holds at every clock edge out of reset
`define SEBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Condition in one cycle implies a consequence in the next
`define SEBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEBD_ASSERT(lbl, prop, msg)
`define SEBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/sebd_pkg.sv =====
package sebd_pkg;

  // Event kinds as seen on the output
  typedef enum logic [1:0] {
    KIND_CCW  = 2'd0,
    KIND_CW   = 2'd1,
    KIND_PUSH = 2'd2
  } kind_e;

  // Turn mode register codes; other codes suppress turn events
  localparam logic [1:0] MODE_CTRL      = 2'd0;
  localparam logic [1:0] MODE_SEQUENCER = 2'd1;

  // Scan frame byte holding the A/B pairs of each group of four knobs
  localparam int unsigned GROUP_BYTE [4] = '{0, 2, 3, 5};

  // One event slot of the output chain
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] knob;
  } slot_t;

endpackage

// ===== hw/rtl/sebd_knob_cell.sv =====
module sebd_knob_cell import sebd_pkg::*; #(
  parameter int unsigned KNOB = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  capture_i,
  input  logic  turns_on_i,
  input  logic  a_lvl_i,
  input  logic  b_lvl_i,
  input  logic  btn_lvl_i,
  output slot_t turn_slot_o,
  output slot_t push_slot_o
);

  logic last_b_q, last_b_d;
  logic last_btn_q, last_btn_d;

  // Levels of the previous frame
  always_comb begin
    last_b_d   = capture_i ? b_lvl_i : last_b_q;
    last_btn_d = capture_i ? btn_lvl_i : last_btn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_b_q   <= 1'b0;
      last_btn_q <= 1'b0;
    end else begin
      last_b_q   <= last_b_d;
      last_btn_q <= last_btn_d;
    end
  end

  // B edge while A is low gives a turn; falling button gives a push
  always_comb begin
    turn_slot_o.valid = turns_on_i && !a_lvl_i && (b_lvl_i != last_b_q);
    turn_slot_o.kind  = b_lvl_i ? KIND_CCW : KIND_CW;
    turn_slot_o.knob  = 4'(KNOB);
    push_slot_o.valid = last_btn_q && !btn_lvl_i;
    push_slot_o.kind  = KIND_PUSH;
    push_slot_o.knob  = 4'(KNOB);
  end

endmodule

// ===== hw/rtl/sebd_slot_cell.sv =====
module sebd_slot_cell import sebd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic  shift_i,
  input  slot_t load_slot_i,
  input  slot_t next_slot_i,
  output slot_t slot_o
);

  slot_t slot_q, slot_d;

  // Load a fresh frame's event, or take the neighbor's slot on a shift
  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_slot_i;
    end else if (shift_i) begin
      slot_d = next_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== hw/rtl/scanned_encoder_bank_decoder_top.sv =====
// Scanned encoder bank decoder.
// Input channel: one scan frame item (scan_frame_i, six bytes) on in_valid_i,
// held off by in_stall_o. Output channel: one event item per cycle on
// out_valid_o (event_kind_o, knob_index_o, last_event_o), held by out_stall_i.
// cfg_we_i/cfg_wdata_i write the turn mode; write it only while idle.
// An accepted frame is compared against the stored levels in one knob cell
// per knob and its events load a chain of 2*KNOB_COUNT slots, turns first,
// pushes after. The chain shifts one slot per cycle toward the output
// register unless a stalled output holds it; the head slot moves into the
// output register, and a frame holds the chain until its last event has
// left it. A frame without events does not hold the chain. The next frame is
// accepted in the cycle the previous frame's last event leaves the chain.
// A stalled output freezes the chain and the output register.
// Reset clears the stored levels, the turn mode (controller) and all slots.
`include "scanned_encoder_bank_decoder_top_defines.svh"

module scanned_encoder_bank_decoder_top import sebd_pkg::*; #(
  parameter int unsigned KNOB_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] scan_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  knob_index_o,
  output logic        last_event_o
);

  localparam int unsigned SLOTS = 2 * KNOB_COUNT;

  logic [1:0] mode_q;
  logic       turns_on;
  logic       accept;
  logic       advance;
  logic       rest_busy;
  logic       any_busy;
  logic       room;

  slot_t            load_slot [SLOTS];
  slot_t            slot      [SLOTS];
  logic [SLOTS-1:0] slot_valid;

  logic       out_valid_q;
  kind_e      kind_q;
  logic [3:0] knob_q;
  logic       last_q;

  // Turn mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CTRL;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign turns_on = (mode_q == MODE_CTRL) || (mode_q == MODE_SEQUENCER);

  // Handshake: take a frame once the chain holds nothing beyond a head that moves out
  always_comb begin
    advance    = !out_valid_q || !out_stall_i;
    rest_busy  = |slot_valid[SLOTS-1:1];
    any_busy   = |slot_valid;
    room       = advance ? !rest_busy : !any_busy;
    in_stall_o = !room;
    accept     = in_valid_i && room;
  end

  // Knob cells: unpack levels and detect events
  for (genvar i = 0; i < KNOB_COUNT; i++) begin : g_knob
    localparam int unsigned GB      = GROUP_BYTE[i / 4];
    localparam int unsigned A_POS   = 8 * GB + 7 - 2 * (i % 4);
    localparam int unsigned B_POS   = 8 * GB + 6 - 2 * (i % 4);
    localparam int unsigned BTN_POS = (i < 8) ? (15 - i) : (47 - i);

    sebd_knob_cell #(
      .KNOB (i)
    ) u_knob (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .capture_i   (accept),
      .turns_on_i  (turns_on),
      .a_lvl_i     (scan_frame_i[A_POS]),
      .b_lvl_i     (scan_frame_i[B_POS]),
      .btn_lvl_i   (scan_frame_i[BTN_POS]),
      .turn_slot_o (load_slot[i]),
      .push_slot_o (load_slot[KNOB_COUNT + i])
    );
  end

  // Slot chain, head at slot 0
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    slot_t next_slot;
    if (s == SLOTS - 1) begin : g_tail
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slot[s + 1];
    end

    sebd_slot_cell u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (accept),
      .shift_i     (advance),
      .load_slot_i (load_slot[s]),
      .next_slot_i (next_slot),
      .slot_o      (slot[s])
    );

    assign slot_valid[s] = slot[s].valid;
  end

  // Output register; head is last when nothing follows it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= slot[0].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= slot[0].kind;
      knob_q <= slot[0].knob;
      last_q <= !rest_busy;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign knob_index_o = knob_q;
  assign last_event_o = last_q;

  // A frame loads only into a chain that holds nothing beyond its head slot
  `SEBD_ASSERT(a_load_empty, !accept || (slot_valid[SLOTS-1:1] == '0), "frame loaded over pending events")
  // An event not flagged last always has a successor waiting in the chain
  `SEBD_ASSERT(a_successor, !(out_valid_q && !last_q) || any_busy, "non-final event without successor")
  // The final event leaves the chain empty unless a new frame loads
  `SEBD_ASSERT_NEXT(a_drain, advance && slot[0].valid && !rest_busy && !accept, slot_valid == '0, "chain not empty after final event")

endmodule

// ===== verif/scanned_encoder_bank_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module scanned_encoder_bank_decoder_top_tb;
  import sebd_pkg::*;

  localparam int unsigned KNOBS = 16;
  // Cycles to let the event chain empty before touching the mode register
  localparam int unsigned DRAIN_CYCLES = 2 * KNOBS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 36;

  // Frames used by the directed tests (byte 5 on the left)
  localparam logic [47:0] FRAME_QUIET   = 48'h0;
  localparam logic [47:0] FRAME_ONES    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] FRAME_B_ONLY  = 48'h5500_5555_0055;
  localparam logic [47:0] FRAME_A_ONLY  = 48'hAA00_AAAA_00AA;
  localparam logic [47:0] FRAME_AB      = 48'hFF00_FFFF_00FF;
  localparam logic [47:0] FRAME_BUTTONS = 48'h00FF_0000_FF00;
  localparam logic [47:0] FRAME_KNOB0_B = 48'h0000_0000_0040;
  localparam logic [47:0] FRAME_KNOB15_B = 48'h0100_0000_0040;
  localparam logic [47:0] FRAME_BTN_TOP = 48'h0000_0000_8000;
  localparam logic [47:0] FRAME_BTN_LOW = 48'h0001_0000_0000;

  typedef struct {
    kind_e      kind;
    logic [3:0] knob;
    logic       last;
  } knob_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [47:0] scan_frame_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  event_kind_o;
  logic [3:0]  knob_index_o;
  logic        last_event_o;

  // Predictor state
  logic [1:0]  turn_mode_q;
  logic [15:0] prev_b_levels;
  logic [15:0] prev_buttons;
  knob_event_t pending_events[$];
  knob_event_t got_event;

  int unsigned errors;
  int unsigned frames_sent;
  int unsigned events_seen;
  int unsigned idle_cycles;

  // Sender and receiver idling knobs
  int unsigned burst_left;
  int unsigned burst_max;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned stall_run_left;
  logic        stalling;

  scanned_encoder_bank_decoder_top #(
    .KNOB_COUNT(KNOBS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .scan_frame_i (scan_frame_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .knob_index_o (knob_index_o),
    .last_event_o (last_event_o)
  );

  always #5 clk_i = ~clk_i;

  // Unpack one frame, queue its events, update the stored levels
  function automatic void predict_frame_events(input logic [47:0] frame);
    logic [15:0] a_lv;
    logic [15:0] b_lv;
    logic [15:0] buttons;
    logic [15:0] falls;
    logic [7:0]  grp;
    knob_event_t ev;
    int unsigned first;
    int unsigned j;
    for (int i = 0; i < 16; i++) begin
      grp = frame[8 * GROUP_BYTE[i >> 2] +: 8];
      j = i % 4;
      a_lv[i] = grp[7 - 2 * j];
      b_lv[i] = grp[6 - 2 * j];
    end
    buttons = {frame[15:8], frame[39:32]};
    first = pending_events.size();
    ev.last = 1'b0;
    if (turn_mode_q == MODE_CTRL || turn_mode_q == MODE_SEQUENCER) begin
      for (int i = 0; i < KNOBS; i++) begin
        if (!a_lv[i] && (b_lv[i] != prev_b_levels[i])) begin
          ev.kind = b_lv[i] ? KIND_CCW : KIND_CW;
          ev.knob = i[3:0];
          pending_events.push_back(ev);
        end
      end
    end
    falls = (buttons ^ prev_buttons) & ~buttons;
    for (int i = 0; i < KNOBS; i++) begin
      if (falls[15 - i]) begin
        ev.kind = KIND_PUSH;
        ev.knob = i[3:0];
        pending_events.push_back(ev);
      end
    end
    // flag the final event of this frame
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
    prev_b_levels = b_lv;
    prev_buttons = buttons;
  endfunction

  // Offer one frame, honoring the burst/gap pattern; returns at acceptance
  task automatic send_frame(input logic [47:0] frame);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    scan_frame_i <= frame;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame_events(frame);
    frames_sent++;
  endtask

  // Stop sending and let every queued event come out
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_turn_mode(input logic [1:0] mode);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    turn_mode_q = mode;
    cfg_we_i <= 1'b0;
  endtask

  // Quiet frame, full-bank turns both ways, A-high edges, all buttons
  task automatic test_bank_extremes;
    set_turn_mode(MODE_CTRL);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_ONES);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_B_ONLY);
    send_frame(FRAME_A_ONLY);
    send_frame(FRAME_AB);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_BUTTONS);
    send_frame(FRAME_QUIET);
  endtask

  // First and last knob, top and bottom button bit
  task automatic test_single_knobs;
    send_frame(FRAME_KNOB0_B);
    send_frame(FRAME_KNOB15_B);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_BTN_TOP);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_BTN_LOW);
    send_frame(FRAME_QUIET);
  endtask

  // Other modes hide turns but still store B; pushes still come out
  task automatic test_turn_suppress;
    set_turn_mode(2'd2);
    send_frame(FRAME_B_ONLY);
    set_turn_mode(2'd3);
    send_frame(FRAME_BUTTONS);
    send_frame(FRAME_QUIET);
    send_frame(FRAME_B_ONLY);
    set_turn_mode(MODE_SEQUENCER);
    send_frame(FRAME_QUIET);
  endtask

  // Mostly quadrature-stepped knobs and button presses, some noise frames
  task automatic test_random_frames;
    logic [1:0]  gray_seq [4];
    logic [1:0]  phase_pos [16];
    logic [15:0] btn_lv;
    logic [47:0] frame;
    logic [1:0]  ab;
    int unsigned k;
    int unsigned g;
    int unsigned j;
    gray_seq = '{2'b00, 2'b01, 2'b11, 2'b10};
    for (int i = 0; i < 16; i++) phase_pos[i] = 2'd0;
    btn_lv = '1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) set_turn_mode(MODE_CTRL);
      else if (ph == 1) set_turn_mode(2'd3);
      else set_turn_mode(2'($urandom_range(0, 3)));
      // one phase runs without idling on either side
      if (ph == 2) begin
        gap_max = 0;
        stall_max = 0;
      end else begin
        gap_max = $urandom_range(1, 8);
        stall_max = $urandom_range(1, 12);
      end
      burst_max = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 2) begin
          frame = 48'({$urandom, $urandom});
        end else begin
          k = $urandom_range(0, 4);
          repeat (k) begin
            j = $urandom_range(0, 15);
            phase_pos[j] = $urandom_range(0, 1) ? phase_pos[j] + 2'd1 : phase_pos[j] - 2'd1;
          end
          if ($urandom_range(0, 2) == 0) btn_lv[$urandom_range(0, 15)] ^= 1'b1;
          frame = '0;
          for (int i = 0; i < 16; i++) begin
            ab = gray_seq[phase_pos[i]];
            g = GROUP_BYTE[i >> 2];
            j = i % 4;
            frame[8 * g + 7 - 2 * j] = ab[1];
            frame[8 * g + 6 - 2 * j] = ab[0];
          end
          frame[15:8] = btn_lv[15:8];
          frame[39:32] = btn_lv[7:0];
        end
        send_frame(frame);
      end
    end
  endtask

  // Receiver stall pattern: alternating free and stalled runs
  always @(posedge clk_i) begin
    if (stall_run_left == 0) begin
      stalling = (stall_max != 0) && !stalling;
      stall_run_left = stalling ? $urandom_range(1, stall_max) : $urandom_range(1, 10);
    end
    stall_run_left--;
    out_stall_i <= stalling;
  end

  // Compare each accepted event with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d knob %0d last %0d",
               event_kind_o, knob_index_o, last_event_o);
        errors++;
      end else begin
        got_event = pending_events.pop_front();
        if (event_kind_o !== got_event.kind) begin
          $error("event_kind expected %0d actual %0d", got_event.kind, event_kind_o);
          errors++;
        end
        if (knob_index_o !== got_event.knob) begin
          $error("knob_index expected %0d actual %0d", got_event.knob, knob_index_o);
          errors++;
        end
        if (last_event_o !== got_event.last) begin
          $error("last_event expected %0d actual %0d", got_event.last, last_event_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    scan_frame_i <= '0;
    out_stall_i <= 1'b0;
    turn_mode_q = MODE_CTRL;
    prev_b_levels = '0;
    prev_buttons = '0;
    errors = 0;
    frames_sent = 0;
    events_seen = 0;
    idle_cycles = 0;
    burst_left = 0;
    burst_max = 6;
    gap_max = 4;
    stall_max = 5;
    stall_run_left = 0;
    stalling = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bank_extremes();
    test_single_knobs();
    test_turn_suppress();
    test_random_frames();
    drain();

    $display("Sent %0d scan frames and checked %0d knob events", frames_sent, events_seen);
    $display("across all four turn mode codes, with and without idling on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
